// ----- hw/rtl/gnss_stream_protocol_detector_defines.svh -----
// Assertion macros used by the checker file of the protocol detector.
`ifndef GNSS_STREAM_PROTOCOL_DETECTOR_DEFINES_SVH
`define GNSS_STREAM_PROTOCOL_DETECTOR_DEFINES_SVH

// Same-cycle implication, sampled on i_clk and quiet while in reset.
`define GSD_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("gsd: same-cycle check failed");

// Next-cycle implication, sampled on i_clk and quiet while in reset.
`define GSD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("gsd: next-cycle check failed");

`endif

// ----- hw/rtl/gsd_pkg.sv -----
`default_nettype none

package gsd_pkg;

    // Width of each saturating hit counter.
    localparam int COUNT_WIDTH = 16;
    // Width of the threshold register.
    localparam int THR_W = 16;
    // Common width used when a counter is compared with the threshold.
    localparam int CMP_W = (COUNT_WIDTH > THR_W) ? COUNT_WIDTH : THR_W;

    localparam int NUM_PROTO = 4;

    // APB address map.
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic REG_IDX_THRESHOLD = 1'b0;
    localparam logic [THR_W-1:0] THRESHOLD_RESET = 16'd3;

    // Item kinds.
    localparam logic KIND_BYTE  = 1'b0;
    localparam logic KIND_CLEAR = 1'b1;

    // Protocol codes.
    localparam logic [2:0] PROTO_UNKNOWN = 3'd0;
    localparam logic [2:0] PROTO_UBX     = 3'd1;
    localparam logic [2:0] PROTO_SBF     = 3'd2;
    localparam logic [2:0] PROTO_NMEA    = 3'd3;
    localparam logic [2:0] PROTO_RTCM3   = 3'd4;

    // Counter slots, in the order thresholds are checked.
    localparam int SLOT_UBX   = 0;
    localparam int SLOT_SBF   = 1;
    localparam int SLOT_NMEA  = 2;
    localparam int SLOT_RTCM3 = 3;

    // Sync pattern bytes.
    localparam logic [7:0] SYNC_UBX_0   = 8'hB5;
    localparam logic [7:0] SYNC_UBX_1   = 8'h62;
    localparam logic [7:0] SYNC_DOLLAR  = 8'h24;
    localparam logic [7:0] SYNC_SBF_1   = 8'h40;
    localparam logic [7:0] SYNC_NMEA_G  = 8'h47;
    localparam logic [7:0] SYNC_NMEA_P  = 8'h50;
    localparam logic [7:0] SYNC_RTCM_0  = 8'hD3;
    localparam logic [7:0] SYNC_RTCM_M  = 8'hFC;

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
        logic       last_of_buffer;
    } t_in_beat;

    typedef struct packed {
        logic [2:0] protocol;
        logic       detected;
    } t_out_beat;

    // Per-counter control from the core.
    typedef struct packed {
        logic clear;
        logic bump;
    } t_cnt_ctl;

endpackage

`default_nettype wire

// ----- hw/rtl/gnss_stream_protocol_detector.sv -----
// Channel   Direction  Handshake                     Payload
// in        sink       i_in_valid / o_in_stall       i_in_data  (t_in_beat)
// out       source     o_out_valid / i_out_stall     o_out_data (t_out_beat)
// config    APB slave  psel, penable, pwrite, pready threshold at byte address 0
//
// One beat is accepted per cycle unless o_in_stall holds it; each result is registered
// behind the input register and core: pair compare, counter increment, threshold compare.
// Synchronous active-low reset clears the pipeline, counters and detection; threshold is 3.
// A stalled output holds its result while the input register keeps taking beats that
// make no result; a beat that makes a result waits in the input register until it fits.
`default_nettype none

module gnss_stream_protocol_detector
    import gsd_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire t_in_beat           i_in_data,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output t_out_beat               o_out_data,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready
);

    logic             r_in_valid;
    t_in_beat         r_in_beat;
    logic             r_out_valid;
    t_out_beat        r_out_beat;
    logic [THR_W-1:0] threshold;
    logic             in_take;
    logic             emits;
    logic             out_free;
    logic             fire;
    t_out_beat        result;

    // Configuration registers.
    gsd_apb_regs u_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .o_threshold (threshold)
    );

    // Pipeline flow: a beat moves into the core unless its result has nowhere to go.
    assign emits      = (r_in_beat.kind == KIND_BYTE) && r_in_beat.last_of_buffer;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign fire       = r_in_valid && (!emits || out_free);
    assign o_in_stall = r_in_valid && !fire;
    assign in_take    = i_in_valid && !o_in_stall;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_beat <= i_in_data;
        end
    end

    gsd_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_beat      (r_in_beat),
        .i_threshold (threshold),
        .o_result    (result)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire && emits) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && emits) begin
            r_out_beat <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_beat;

endmodule

`default_nettype wire

// ----- hw/rtl/gsd_apb_regs.sv -----
`default_nettype none

module gsd_apb_regs
    import gsd_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready,
    output logic      [THR_W-1:0]   o_threshold
);

    logic             wr_en;
    logic [THR_W-1:0] r_threshold;

    // The port never inserts wait states.
    assign pready = 1'b1;

    // A write lands in the access phase; the word address picks the register.
    assign wr_en = psel && penable && pwrite && pready && (paddr[2] == REG_IDX_THRESHOLD);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THRESHOLD_RESET;
        end else if (wr_en) begin
            r_threshold <= pwdata[THR_W-1:0];
        end
    end

    // Read back the threshold; unmapped words read as zero.
    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_IDX_THRESHOLD) begin
            prdata = PDATA_W'(r_threshold);
        end
    end

    assign o_threshold = r_threshold;

endmodule

`default_nettype wire

// ----- hw/rtl/gsd_hit_counter.sv -----
`default_nettype none

module gsd_hit_counter
    import gsd_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_cnt_ctl         i_ctl,
    input  wire logic [THR_W-1:0] i_threshold,
    output logic                  o_reached
);

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    logic [COUNT_WIDTH-1:0] r_count;
    logic [COUNT_WIDTH-1:0] n_count;

    // Saturating increment, with clear taking priority.
    always_comb begin
        n_count = r_count;
        if (i_ctl.clear) begin
            n_count = '0;
        end else if (i_ctl.bump && (r_count != COUNT_MAX)) begin
            n_count = r_count + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // The check at a buffer end sees the count including this beat's hit.
    assign o_reached = CMP_W'(n_count) >= CMP_W'(i_threshold);

endmodule

`default_nettype wire

// ----- hw/rtl/gsd_core.sv -----
`default_nettype none

module gsd_core
    import gsd_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_fire,
    input  wire t_in_beat         i_beat,
    input  wire logic [THR_W-1:0] i_threshold,
    output t_out_beat             o_result
);

    logic [7:0]           r_prev_byte;
    logic                 r_prev_valid;
    logic                 r_locked;
    logic [2:0]           r_found;
    logic [7:0]           n_prev_byte;
    logic                 n_prev_valid;
    logic                 n_locked;
    logic [2:0]           n_found;

    logic                 is_clear;
    logic                 is_active;
    logic                 is_check;
    logic [NUM_PROTO-1:0] hit;
    logic [NUM_PROTO-1:0] reached;
    t_cnt_ctl             cnt_ctl [NUM_PROTO];

    assign is_clear  = i_fire && (i_beat.kind == KIND_CLEAR);
    assign is_active = i_fire && (i_beat.kind == KIND_BYTE) && !r_locked;
    assign is_check  = is_active && i_beat.last_of_buffer;

    // Pair matching against the previous byte of the same buffer, first match wins.
    always_comb begin
        hit = '0;
        if (is_active && r_prev_valid) begin
            if (r_prev_byte == SYNC_UBX_0 && i_beat.data_byte == SYNC_UBX_1) begin
                hit[SLOT_UBX] = 1'b1;
            end else if (r_prev_byte == SYNC_DOLLAR && i_beat.data_byte == SYNC_SBF_1) begin
                hit[SLOT_SBF] = 1'b1;
            end else if (r_prev_byte == SYNC_DOLLAR
                         && (i_beat.data_byte == SYNC_NMEA_G
                             || i_beat.data_byte == SYNC_NMEA_P)) begin
                hit[SLOT_NMEA] = 1'b1;
            end else if (r_prev_byte == SYNC_RTCM_0
                         && (i_beat.data_byte & SYNC_RTCM_M) == 8'h00) begin
                hit[SLOT_RTCM3] = 1'b1;
            end
        end
    end

    // One saturating counter per protocol.
    for (genvar g = 0; g < NUM_PROTO; g++) begin : g_cnt
        assign cnt_ctl[g] = '{clear: is_clear, bump: hit[g]};

        gsd_hit_counter u_cnt (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (cnt_ctl[g]),
            .i_threshold (i_threshold),
            .o_reached   (reached[g])
        );
    end

    // Next state of the pair chain and the latched detection.
    always_comb begin
        n_prev_byte  = r_prev_byte;
        n_prev_valid = r_prev_valid;
        n_locked     = r_locked;
        n_found      = r_found;
        if (is_clear) begin
            n_prev_byte  = 8'h00;
            n_prev_valid = 1'b0;
            n_locked     = 1'b0;
            n_found      = PROTO_UNKNOWN;
        end else if (is_active) begin
            n_prev_byte  = i_beat.data_byte;
            n_prev_valid = !i_beat.last_of_buffer;
            if (is_check) begin
                if (reached[SLOT_UBX]) begin
                    n_locked = 1'b1;
                    n_found  = PROTO_UBX;
                end else if (reached[SLOT_SBF]) begin
                    n_locked = 1'b1;
                    n_found  = PROTO_SBF;
                end else if (reached[SLOT_NMEA]) begin
                    n_locked = 1'b1;
                    n_found  = PROTO_NMEA;
                end else if (reached[SLOT_RTCM3]) begin
                    n_locked = 1'b1;
                    n_found  = PROTO_RTCM3;
                end
            end
        end else if (i_fire) begin
            // Locked: bytes are dropped and the chain is broken.
            n_prev_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_byte  <= 8'h00;
            r_prev_valid <= 1'b0;
            r_locked     <= 1'b0;
            r_found      <= PROTO_UNKNOWN;
        end else begin
            r_prev_byte  <= n_prev_byte;
            r_prev_valid <= n_prev_valid;
            r_locked     <= n_locked;
            r_found      <= n_found;
        end
    end

    // The report reflects the state after this beat.
    assign o_result = '{protocol: n_found, detected: n_locked};

endmodule

`default_nettype wire

// ----- hw/rtl/gsd_checker.sv -----
`default_nettype none

`include "gnss_stream_protocol_detector_defines.svh"

module gsd_checker
    import gsd_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      o_in_stall,
    input wire logic      o_out_valid,
    input wire logic      i_out_stall,
    input wire t_out_beat o_out_data
);

    // Reported protocol is always one of the defined codes.
    `GSD_ASSERT_NOW(a_proto_range, o_out_valid, o_out_data.protocol <= PROTO_RTCM3)

    // Detected is set exactly when a known protocol is reported.
    `GSD_ASSERT_NOW(a_detect_match, o_out_valid, o_out_data.detected == (o_out_data.protocol != PROTO_UNKNOWN))

    // The input only backs up behind a held result.
    `GSD_ASSERT_NOW(a_stall_cause, !o_out_valid, !o_in_stall)

    // A stalled result beat stays put.
    `GSD_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_data))

endmodule

bind gnss_stream_protocol_detector gsd_checker u_gsd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

`default_nettype wire
